// ----- src/crc_frame_deframer_top_defines.svh -----
// Assertion helpers shared by the deframer modules.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef CRC_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define CRC_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cfd_pkg.sv -----
package cfd_pkg;

    localparam int MAX_PAYLOAD  = 64;
    localparam int HEADER_BYTES = 6;
    localparam int IDX_W        = $clog2(MAX_PAYLOAD);
    localparam int CNT_W        = $clog2(MAX_PAYLOAD + 1);
    localparam int BODY_W       = $clog2(HEADER_BYTES + MAX_PAYLOAD + 1);
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int MEM_ADDR_W   = IDX_W + 1;
    localparam int MEM_DEPTH    = 2 * MAX_PAYLOAD;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 3;
    localparam int OUT_DATA_W   = 48;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] RST_START_FIRST  = 8'hAA;
    localparam logic [7:0] RST_START_SECOND = 8'h55;
    localparam logic [7:0] RST_VERSION      = 8'h01;
    localparam logic [6:0] RST_LIMIT        = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT        = 3'd3;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_VER  = 2'd1,
        ST_LEN  = 2'd2,
        ST_CRC  = 2'd3
    } t_status;

    typedef struct packed {
        t_status          status;
        logic [7:0]       ftype;
        logic [15:0]      seq;
        logic [CNT_W-1:0] count;
        logic             bank;
    } t_desc;

    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } t_mem_wr;

    // CRC-16, MSB first, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- src/cfd_front.sv -----
module cfd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    input  logic                             i_valid,
    input  logic                             i_room,
    input  logic [7:0]                       i_byte,
    output logic                             o_push,
    output cfd_pkg::t_desc                   o_desc,
    output cfd_pkg::t_mem_wr                 o_wr
);

    typedef enum logic [2:0] {
        PH_SOF0 = 3'd0,
        PH_SOF1 = 3'd1,
        PH_BODY = 3'd2,
        PH_CRCL = 3'd3,
        PH_CRCH = 3'd4
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [cfd_pkg::BODY_W-1:0]   r_body, n_body;
    logic [15:0]                  r_crc, n_crc;
    logic [7:0]                   r_crc_low, n_crc_low;
    logic [cfd_pkg::CNT_W-1:0]    r_len, n_len;
    logic                         r_bank, n_bank;
    logic [7:0]                   r_hdr [cfd_pkg::HEADER_BYTES];

    logic [7:0]                   r_start_first, r_start_second, r_version;
    logic [6:0]                   r_limit;

    logic                         accept;
    logic                         hdr_we;
    logic [cfd_pkg::HDR_IDX_W-1:0] hdr_idx;
    logic [cfd_pkg::CNT_W-1:0]    limit;
    logic [15:0]                  len_full;
    logic [cfd_pkg::BODY_W-1:0]   pos;

    assign accept   = i_valid && i_room;
    assign limit    = (r_limit > 7'(cfd_pkg::MAX_PAYLOAD)) ?
                      cfd_pkg::CNT_W'(cfd_pkg::MAX_PAYLOAD) : cfd_pkg::CNT_W'(r_limit);
    assign len_full = {i_byte, r_hdr[4]};
    assign pos      = r_body - cfd_pkg::BODY_W'(cfd_pkg::HEADER_BYTES);
    assign hdr_idx  = r_body[cfd_pkg::HDR_IDX_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_body    = r_body;
        n_crc     = r_crc;
        n_crc_low = r_crc_low;
        n_len     = r_len;
        n_bank    = r_bank;
        hdr_we    = 1'b0;
        o_push    = 1'b0;
        o_desc    = '{status: cfd_pkg::ST_GOOD, ftype: 8'h00, seq: 16'h0000,
                      count: '0, bank: r_bank};
        o_wr      = '{en: 1'b0, addr: {r_bank, pos[cfd_pkg::IDX_W-1:0]}, data: i_byte};
        if (accept) begin
            unique case (r_phase)
                PH_SOF0: begin
                    if (i_byte == r_start_first) begin
                        n_phase = PH_SOF1;
                    end
                end
                PH_SOF1: begin
                    if (i_byte == r_start_second) begin
                        n_phase = PH_BODY;
                        n_body  = '0;
                        n_crc   = cfd_pkg::CRC_INIT;
                    end else if (i_byte != r_start_first) begin
                        n_phase = PH_SOF0;
                    end
                end
                PH_BODY: begin
                    n_crc  = cfd_pkg::crc_byte(r_crc, i_byte);
                    n_body = r_body + 1'b1;
                    if (r_body < cfd_pkg::BODY_W'(cfd_pkg::HEADER_BYTES)) begin
                        hdr_we = 1'b1;
                        if (r_body == cfd_pkg::BODY_W'(cfd_pkg::HEADER_BYTES - 1)) begin
                            n_len = len_full[cfd_pkg::CNT_W-1:0];
                            if (r_hdr[0] != r_version) begin
                                o_push        = 1'b1;
                                o_desc.status = cfd_pkg::ST_VER;
                            end else if (len_full > 16'(limit)) begin
                                o_push        = 1'b1;
                                o_desc.status = cfd_pkg::ST_LEN;
                            end else if (len_full == 16'h0000) begin
                                n_phase = PH_CRCL;
                            end
                        end
                    end else begin
                        o_wr.en = 1'b1;
                        if (pos + 1'b1 >= cfd_pkg::BODY_W'(r_len)) begin
                            n_phase = PH_CRCL;
                        end
                    end
                end
                PH_CRCL: begin
                    n_crc_low = i_byte;
                    n_phase   = PH_CRCH;
                end
                PH_CRCH: begin
                    o_push = 1'b1;
                    if ({i_byte, r_crc_low} != r_crc) begin
                        o_desc.status = cfd_pkg::ST_CRC;
                    end else begin
                        o_desc.ftype = r_hdr[1];
                        o_desc.seq   = {r_hdr[3], r_hdr[2]};
                        o_desc.count = r_len;
                        n_bank       = ~r_bank;
                    end
                end
                default: begin
                    n_phase = PH_SOF0;
                end
            endcase
            // any result or a stray phase code sends the parser back to hunting
            if (o_push || !(r_phase == PH_SOF0 || r_phase == PH_SOF1 || r_phase == PH_BODY
                            || r_phase == PH_CRCL || r_phase == PH_CRCH)) begin
                n_phase   = PH_SOF0;
                n_body    = '0;
                n_crc     = cfd_pkg::CRC_INIT;
                n_crc_low = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SOF0;
            r_body         <= '0;
            r_crc          <= cfd_pkg::CRC_INIT;
            r_crc_low      <= 8'h00;
            r_len          <= '0;
            r_bank         <= 1'b0;
            r_start_first  <= cfd_pkg::RST_START_FIRST;
            r_start_second <= cfd_pkg::RST_START_SECOND;
            r_version      <= cfd_pkg::RST_VERSION;
            r_limit        <= cfd_pkg::RST_LIMIT;
        end else begin
            r_phase   <= n_phase;
            r_body    <= n_body;
            r_crc     <= n_crc;
            r_crc_low <= n_crc_low;
            r_len     <= n_len;
            r_bank    <= n_bank;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    cfd_pkg::CFG_START_FIRST:  r_start_first  <= i_cfg_data;
                    cfd_pkg::CFG_START_SECOND: r_start_second <= i_cfg_data;
                    cfd_pkg::CFG_VERSION:      r_version      <= i_cfg_data;
                    cfd_pkg::CFG_LIMIT:        r_limit        <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[hdr_idx] <= i_byte;
        end
    end

endmodule

// ----- src/cfd_queue.sv -----
`include "crc_frame_deframer_top_defines.svh"

module cfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cfd_pkg::t_desc   i_desc,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output cfd_pkg::t_desc   o_head
);

    cfd_pkg::t_desc               r_entry [cfd_pkg::QUEUE_DEPTH];
    logic [cfd_pkg::QPTR_W-1:0]   r_wptr, r_rptr;
    logic [cfd_pkg::QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + cfd_pkg::QCNT_W'(i_push) - cfd_pkg::QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_desc;
        end
    end

    `CFD_ASSERT_NOW(a_no_push_full, i_push, !o_full, "descriptor pushed into full queue")
    `CFD_ASSERT_NOW(a_no_pop_empty, i_pop, o_valid, "descriptor popped from empty queue")

endmodule

// ----- src/cfd_back.sv -----
`include "crc_frame_deframer_top_defines.svh"

module cfd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cfd_pkg::t_mem_wr                   i_wr,
    input  logic                               i_head_valid,
    input  cfd_pkg::t_desc                     i_head,
    output logic                               o_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cfd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_SHOW = 2'd2
    } t_state;

    t_state                      r_state;
    logic [cfd_pkg::IDX_W-1:0]   r_idx;
    logic [7:0]                  r_mem [cfd_pkg::MEM_DEPTH];
    logic [7:0]                  r_rdata;
    logic                        last;
    logic [7:0]                  pbyte;

    assign last  = (i_head.count == '0) ||
                   (cfd_pkg::CNT_W'(r_idx) == i_head.count - 1'b1);
    assign pbyte = (i_head.count == '0) ? 8'h00 : r_rdata;
    assign o_pop = (r_state == S_SHOW) && m_axis_tready && last;

    assign m_axis_tvalid = (r_state == S_SHOW);
    assign m_axis_tuser  = i_head.status;
    assign m_axis_tlast  = last;
    assign m_axis_tdata  = {3'b000, r_idx, pbyte, i_head.count, i_head.seq, i_head.ftype};

    // payload banks: the front fills one while this side drains the other
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[{i_head.bank, r_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_SHOW;
                end
                S_SHOW: begin
                    if (m_axis_tready) begin
                        if (last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CFD_ASSERT_NOW(a_show_has_head, r_state == S_SHOW, i_head_valid, "result shown without descriptor")
    `CFD_ASSERT_NEXT(a_pop_to_idle, o_pop, r_state == S_IDLE, "run not closed after last word")

endmodule

// ----- src/crc_frame_deframer_top.sv -----
// Input: one byte per cycle while the descriptor queue has room; the queue holds two frames.
// Output: words leave one at a time: each is read in S_READ, then held in S_SHOW until taken.
// The back end reads the payload RAM once per word, which sets the output rate.
// Input stalls only while two finished frames wait in the queue.
// Reset is synchronous, active low: hunt for start bytes, registers to their defaults.
// The payload RAM is not cleared; entries are read only after being written.
module crc_frame_deframer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] frame_type, [23:8] sequence_res, [30:24] payload_count,
    // [38:31] payload_byte, [44:39] byte_index, [47:45] zero
    output logic [cfd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,  // [1:0] status
    output logic                                m_axis_tlast
);

    logic             push, pop, full, head_valid;
    cfd_pkg::t_desc   desc, head;
    cfd_pkg::t_mem_wr wr;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !full;

    cfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_room      (!full),
        .i_byte      (s_axis_tdata),
        .o_push      (push),
        .o_desc      (desc),
        .o_wr        (wr)
    );

    cfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    cfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (wr),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
